>>> sv/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg: shared types, constants and functions for the packet crc checker
// holds the crc-32 byte update, header layout constants and the record
// that travels from the byte front end to the counting back end
// ----------------------------------------------------------------------------
package pcc_pkg;

  // counter width of the good and error totals
  localparam int COUNT_WIDTH = 48;
  // width of the total fields on the result channel
  localparam int TOTAL_WIDTH = 48;

  // crc-32 (reflected form)
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // header capture
  localparam logic [3:0] HDR_BYTES = 4'd8;

  // record queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // one finished packet as seen by the front end
  typedef struct packed {
    logic        crc_ok;
    logic [47:0] frame_number;
    logic [7:0]  source_id;
    logic [7:0]  dest_id;
  } pkt_rec_t;

  // queue status toward the producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // one byte through the reflected crc-32 register, one bit per step
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] crc;
    crc = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      crc = {1'b0, crc[31:1]} ^ (CRC_POLY & {32{crc[0]}});
    end
    return crc;
  endfunction

endpackage

>>> sv/packet_crc32_checker_unit.sv
// ----------------------------------------------------------------------------
// packet_crc32_checker_unit: crc-32 packet checker with header capture
// path: crc folded combinationally per byte, record queue, then output register
// throughput: one byte per cycle while the queue has room, one result per cycle
// when taken; the 4-entry record queue lets the byte side run while results wait
// reset: synchronous active-low rst_n clears crc, header, queue and totals
// ----------------------------------------------------------------------------
module packet_crc32_checker_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // end_of_packet
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // [47:0] frame_number, [55:48] source_id,
                                   // [63:56] dest_id, [111:64] good_total,
                                   // [159:112] error_total
  output logic         out_tuser   // crc_ok
);

  pcc_pkg::queue_status_t q_status;
  pcc_pkg::pkt_rec_t      push_rec;
  pcc_pkg::pkt_rec_t      head_rec;
  logic                   push;
  logic                   pop;

  // byte front end
  pcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_status  (q_status),
    .push      (push),
    .push_rec  (push_rec)
  );

  // record queue
  pcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .status   (q_status)
  );

  // counting back end
  pcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> sv/pcc_front.sv
// ----------------------------------------------------------------------------
// pcc_front: byte front end of the packet crc checker
// runs the crc over each byte, captures the eight-byte big-endian header
// and pushes one record into the queue on the last byte of a packet
// ----------------------------------------------------------------------------
module pcc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,   // end_of_packet
  input  pcc_pkg::queue_status_t q_status,
  output logic                   push,
  output pcc_pkg::pkt_rec_t      push_rec
);

  logic [31:0] crc_r, crc_nxt, crc_cur;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] hdr_r, hdr_nxt, hdr_cur;
  logic        accept;

  // a byte may enter whenever the record queue is not full
  assign in_tready = ~q_status.full;
  assign accept    = in_tvalid & in_tready;
  assign push      = accept & in_tlast;

  // crc and header with the current byte folded in
  always_comb begin
    crc_cur = pcc_pkg::crc_byte(crc_r, in_tdata);
    hdr_cur = hdr_r;
    if (pos_r < pcc_pkg::HDR_BYTES) begin
      hdr_cur[{~pos_r[2:0], 3'b000} +: 8] = in_tdata;
    end
  end

  // record for the back end
  always_comb begin
    push_rec.crc_ok       = (crc_cur == 32'd0);
    push_rec.frame_number = hdr_cur[63:16];
    push_rec.source_id    = hdr_cur[15:8];
    push_rec.dest_id      = hdr_cur[7:0];
  end

  // packet state update
  always_comb begin
    crc_nxt = crc_r;
    pos_nxt = pos_r;
    hdr_nxt = hdr_r;
    if (accept) begin
      if (in_tlast) begin
        crc_nxt = pcc_pkg::CRC_INIT;
        pos_nxt = 4'd0;
        hdr_nxt = 64'd0;
      end else begin
        crc_nxt = crc_cur;
        hdr_nxt = hdr_cur;
        if (pos_r < pcc_pkg::HDR_BYTES) begin
          pos_nxt = pos_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= pcc_pkg::CRC_INIT;
      pos_r <= 4'd0;
      hdr_r <= 64'd0;
    end else begin
      crc_r <= crc_nxt;
      pos_r <= pos_nxt;
      hdr_r <= hdr_nxt;
    end
  end

endmodule

>>> sv/pcc_queue.sv
// ----------------------------------------------------------------------------
// pcc_queue: short record queue between front and back end
// small register fifo with a fill count, head read without delay
// ----------------------------------------------------------------------------
module pcc_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  pcc_pkg::pkt_rec_t      push_rec,
  input  logic                   pop,
  output pcc_pkg::pkt_rec_t      head_rec,
  output pcc_pkg::queue_status_t status
);

  pcc_pkg::pkt_rec_t                 entry_r [pcc_pkg::QUEUE_DEPTH];
  logic [pcc_pkg::QUEUE_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [pcc_pkg::QUEUE_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [pcc_pkg::QUEUE_AW:0]        cnt_r, cnt_nxt;
  logic                              do_push, do_pop;

  // status from the fill count
  assign status.full  = (cnt_r == (pcc_pkg::QUEUE_AW+1)'(pcc_pkg::QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign head_rec     = entry_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

>>> sv/pcc_back.sv
// ----------------------------------------------------------------------------
// pcc_back: counting back end of the packet crc checker
// pops packet records, bumps the saturating good and error totals and
// holds each result in an output register until it is taken
// ----------------------------------------------------------------------------
module pcc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pcc_pkg::queue_status_t q_status,
  input  pcc_pkg::pkt_rec_t      head_rec,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [159:0]           out_tdata,  // frame_number, source_id, dest_id,
                                             // good_total, error_total
  output logic                   out_tuser   // crc_ok
);

  logic [pcc_pkg::COUNT_WIDTH-1:0] good_r, good_nxt;
  logic [pcc_pkg::COUNT_WIDTH-1:0] err_r, err_nxt;
  logic                            valid_r, valid_nxt;
  logic [159:0]                    data_r, data_nxt;
  logic                            ok_r, ok_nxt;

  // take a record when the output register is free or being drained
  assign pop = ~q_status.empty & (~valid_r | out_tready);

  // counters and result word
  always_comb begin
    good_nxt  = good_r;
    err_nxt   = err_r;
    valid_nxt = valid_r & ~out_tready;
    data_nxt  = data_r;
    ok_nxt    = ok_r;
    if (pop) begin
      if (head_rec.crc_ok) begin
        if (good_r != '1) good_nxt = good_r + 1'b1;
      end else begin
        if (err_r != '1) err_nxt = err_r + 1'b1;
      end
      valid_nxt = 1'b1;
      ok_nxt    = head_rec.crc_ok;
      data_nxt  = {pcc_pkg::TOTAL_WIDTH'(err_nxt),
                   pcc_pkg::TOTAL_WIDTH'(good_nxt),
                   head_rec.dest_id,
                   head_rec.source_id,
                   head_rec.frame_number};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_r  <= '0;
      err_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      good_r  <= good_nxt;
      err_r   <= err_nxt;
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    ok_r   <= ok_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = ok_r;

endmodule

>>> sv/pcc_checker.sv
// ----------------------------------------------------------------------------
// pcc_checker: port-level checks for the packet crc checker
// watches the result channel for held transfers and consistent totals
// ----------------------------------------------------------------------------
module pcc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata,
  input logic         out_tuser
);

  // no result right after a reset cycle
  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // a passing packet is counted in the good total
  a_good_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[111:64] != 48'd0)
    else $error("good total zero on a passing packet");

  // a failing packet is counted in the error total
  a_error_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[159:112] != 48'd0)
    else $error("error total zero on a failing packet");

endmodule

bind packet_crc32_checker_unit pcc_checker u_pcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> dv/packet_crc32_checker_unit_tb.sv
// ----------------------------------------------------------------------------
// packet_crc32_checker_unit_tb: self-checking bench for the crc-32 packet checker
// streams packets byte by byte (directed table, then random packets with
// valid or corrupted trailing crc) under several idle and stall mixes, and
// checks every result transfer against the hand-written result of a typed row
// or a cycle-free model of crc, header capture and saturating good/error totals
// ----------------------------------------------------------------------------
module packet_crc32_checker_unit_tb;

  // one result as it leaves the block
  typedef struct packed {
    logic        crc_ok;
    logic [47:0] frame_number;
    logic [7:0]  source_id;
    logic [7:0]  dest_id;
    logic [47:0] good_total;
    logic [47:0] error_total;
  } report_t;

  // one directed byte, with a hand-written result on some final bytes
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    report_t    exp;
  } dir_row_t;

  localparam int          STALL_LIMIT  = 2000;
  localparam int          TAIL_CYCLES  = 20;
  localparam int          RANDOM_ITEMS = 1850;
  localparam int          PHASE_RUNS   = 8;
  localparam int          MAX_SHOWN    = 10;
  localparam logic [31:0] CRC_PASS     = 32'hFFFFFFFF;
  localparam logic [3:0]  HDR_LEN      = 4'd8;

  // idle mixes: none, sender idle, receiver stall, both
  localparam int SEND_PCT [4] = '{0, 59, 0, 12};
  localparam int RECV_PCT [4] = '{0, 0, 59, 12};

  // directed packets: single zero byte, single ones byte, check string with
  // its register appended, long all-ones header packet, short packet
  localparam dir_row_t DIRECTED [26] = '{
    '{8'h00, 1'b1, 1'b1, '{1'b0, 48'h0, 8'h00, 8'h00, 48'd0, 48'd1}},
    '{8'hFF, 1'b1, 1'b1, '{1'b0, 48'hFF0000000000, 8'h00, 8'h00, 48'd0, 48'd2}},
    '{8'h31, 1'b0, 1'b0, '0},
    '{8'h32, 1'b0, 1'b0, '0},
    '{8'h33, 1'b0, 1'b0, '0},
    '{8'h34, 1'b0, 1'b0, '0},
    '{8'h35, 1'b0, 1'b0, '0},
    '{8'h36, 1'b0, 1'b0, '0},
    '{8'h37, 1'b0, 1'b0, '0},
    '{8'h38, 1'b0, 1'b0, '0},
    '{8'h39, 1'b0, 1'b0, '0},
    '{8'hD9, 1'b0, 1'b0, '0},
    '{8'hC6, 1'b0, 1'b0, '0},
    '{8'h0B, 1'b0, 1'b0, '0},
    '{8'h34, 1'b1, 1'b1, '{1'b1, 48'h313233343536, 8'h37, 8'h38, 48'd1, 48'd2}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'hA5, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b1, 1'b0, '0}
  };

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = 8'h00;  // [7:0] data_byte
  logic         in_tlast   = 1'b0;   // end_of_packet
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;  // [47:0] frame_number, [55:48] source_id,
                            // [63:56] dest_id, [111:64] good_total,
                            // [159:112] error_total
  logic         out_tuser;  // crc_ok

  // bench-side companions of the byte being offered
  logic    in_typed     = 1'b0;
  report_t in_typed_exp = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int stall_cycles   = 0;

  // model state
  logic [31:0]                     crc_reg;
  logic [3:0]                      header_count;
  logic [63:0]                     header_word;
  logic [pcc_pkg::COUNT_WIDTH-1:0] pass_count;
  logic [pcc_pkg::COUNT_WIDTH-1:0] bad_count;

  report_t pending_reports [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  packet_crc32_checker_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // reflected crc-32 register, one data bit per step
  function automatic logic [31:0] crc32_shift_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ pcc_pkg::CRC_POLY;
    end
    return r;
  endfunction

  // fold one accepted byte into the model, report on the final byte
  task automatic absorb_byte(input logic [7:0] b, input logic last,
                             output logic done, output report_t r);
    logic ok;
    crc_reg = crc32_shift_byte(crc_reg, b);
    if (header_count < HDR_LEN) begin
      header_word  = header_word | ({56'd0, b} << (56 - 8 * header_count));
      header_count = header_count + 4'd1;
    end
    done = last;
    r    = '0;
    if (last) begin
      ok = ((~crc_reg) == CRC_PASS);
      if (ok) begin
        if (pass_count != '1) pass_count = pass_count + 1'b1;
      end else begin
        if (bad_count != '1) bad_count = bad_count + 1'b1;
      end
      r.crc_ok       = ok;
      r.frame_number = header_word[63:16];
      r.source_id    = header_word[15:8];
      r.dest_id      = header_word[7:0];
      r.good_total   = 48'(pass_count);
      r.error_total  = 48'(bad_count);
      crc_reg      = pcc_pkg::CRC_INIT;
      header_count = '0;
      header_word  = '0;
    end
  endtask

  // predict on input transfers, check output transfers, watchdog
  always @(posedge clk) begin
    logic    done;
    report_t r;
    report_t got;
    report_t want;
    if (!rst_n) begin
      crc_reg      = pcc_pkg::CRC_INIT;
      header_count = '0;
      header_word  = '0;
      pass_count   = '0;
      bad_count    = '0;
      stall_cycles <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_byte(in_tdata, in_tlast, done, r);
        if (done) pending_reports.push_back(in_typed ? in_typed_exp : r);
      end
      if (out_tvalid && out_tready) begin
        got.crc_ok       = out_tuser;
        got.frame_number = out_tdata[47:0];
        got.source_id    = out_tdata[55:48];
        got.dest_id      = out_tdata[63:56];
        got.good_total   = out_tdata[111:64];
        got.error_total  = out_tdata[159:112];
        if (pending_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("unexpected result: ok=%0d frame=%h src=%h dst=%h good=%0d err=%0d",
                     got.crc_ok, got.frame_number, got.source_id, got.dest_id,
                     got.good_total, got.error_total);
        end else begin
          want = pending_reports.pop_front();
          if (got.crc_ok !== want.crc_ok || got.frame_number !== want.frame_number ||
              got.source_id !== want.source_id || got.dest_id !== want.dest_id ||
              got.good_total !== want.good_total || got.error_total !== want.error_total) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN) begin
              $display("mismatch exp: ok=%0d frame=%h src=%h dst=%h good=%0d err=%0d",
                       want.crc_ok, want.frame_number, want.source_id, want.dest_id,
                       want.good_total, want.error_total);
              $display("         got: ok=%0d frame=%h src=%h dst=%h good=%0d err=%0d",
                       got.crc_ok, got.frame_number, got.source_id, got.dest_id,
                       got.good_total, got.error_total);
            end
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // offer one byte, with random idle cycles ahead, until it is taken
  task automatic push_byte(input logic [7:0] b, input logic last,
                           input logic typed, input report_t exp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tdata     <= b;
    in_tlast     <= last;
    in_typed     <= typed;
    in_typed_exp <= exp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold the sender off until every pending result has arrived
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // payload bytes lean toward all zeros and all ones
  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 8'h00;
    if (roll < 20) return 8'hFF;
    return 8'($urandom);
  endfunction

  // one random packet: mostly well formed with its register appended
  task automatic send_packet(inout int count);
    logic [7:0]  bytes [$];
    logic [31:0] reg_val;
    int          kind;
    int          len;
    int          pos;
    kind = $urandom_range(99);
    bytes.delete();
    if (kind < 60) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      reg_val = pcc_pkg::CRC_INIT;
      for (int i = 0; i < len; i++) begin
        bytes.push_back(pick_byte());
        reg_val = crc32_shift_byte(reg_val, bytes[i]);
      end
      // little-endian register bytes clear the register
      for (int i = 0; i < 4; i++) bytes.push_back(reg_val[8*i +: 8]);
      // occasional single-bit corruption anywhere in the packet
      if ($urandom_range(7) == 0) begin
        pos = $urandom_range(bytes.size() - 1);
        bytes[pos] = bytes[pos] ^ (8'h01 << $urandom_range(7));
      end
    end else begin
      len = (kind < 85) ? $urandom_range(1, 20) : $urandom_range(1, 7);
      for (int i = 0; i < len; i++) bytes.push_back(pick_byte());
    end
    foreach (bytes[i]) push_byte(bytes[i], i == bytes.size() - 1, 1'b0, '0);
    count += bytes.size();
  endtask

  // main sequence
  initial begin
    int phase_items;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = SEND_PCT[3];
    recv_stall_pct = RECV_PCT[3];
    foreach (DIRECTED[i])
      push_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].exp);
    drain_results();

    for (int run = 0; run < PHASE_RUNS; run++) begin
      send_idle_pct  = SEND_PCT[run % 4];
      recv_stall_pct = RECV_PCT[run % 4];
      phase_items    = 0;
      while (phase_items < RANDOM_ITEMS / PHASE_RUNS) send_packet(phase_items);
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/pcc_pkg.sv
sv/pcc_front.sv
sv/pcc_queue.sv
sv/pcc_back.sv
sv/packet_crc32_checker_unit.sv
sv/pcc_checker.sv
dv/packet_crc32_checker_unit_tb.sv
